### rtl/core/fte_pkg.sv
package fte_pkg;

  // Table geometry.
  localparam int MAX_BLOCKS        = 1024;
  localparam int ENTRIES_PER_BLOCK = 128;
  localparam int TABLE_START       = 1;

  // Field widths.
  localparam int ADDR_W  = 10;
  localparam int VALUE_W = 11;
  localparam int SIZE_W  = 11;

  localparam logic [SIZE_W-1:0] DISK_BLOCKS_RESET = 11'd1024;

  // Entry codes.
  localparam logic signed [VALUE_W-1:0] CODE_FREE     = -11'sd1;
  localparam logic signed [VALUE_W-1:0] CODE_RESERVED = -11'sd2;
  localparam logic signed [VALUE_W-1:0] CODE_INODE    = -11'sd3;
  localparam logic signed [VALUE_W-1:0] CODE_END      = -11'sd4;

  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_ALLOC  = 2'd2,
    FUNC_FORMAT = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_NOT_READY = 3'd1,
    STATUS_RANGE     = 3'd2,
    STATUS_VALUE     = 3'd3,
    STATUS_NO_FREE   = 3'd4
  } status_t;

  // Which result the datapath should build in this cycle.
  typedef enum logic [3:0] {
    RK_NONE,
    RK_NOT_READY,
    RK_RANGE,
    RK_VALUE,
    RK_NO_FREE,
    RK_READ,
    RK_WRITE,
    RK_ALLOC,
    RK_FORMAT
  } res_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_SCAN,
    ST_FORMAT,
    ST_DONE
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;
    logic      rd_issue;
    logic      scan_start;
    logic      scan_run;
    logic      fmt_start;
    logic      fmt_run;
    res_kind_t res;
    logic      out_load;
  } fte_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t func;
    logic  in_range;
    logic  value_ok;
    logic  scan_hit;
    logic  scan_done;
    logic  fmt_last;
    logic  out_free;
  } fte_stat_t;

endpackage

### rtl/core/fte_ctrl.sv
module fte_ctrl
  import fte_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  fte_stat_t stat,
  output fte_cmd_t  cmd
);

  ctrl_state_t state, state_next;
  logic        tbl_ready, tbl_ready_next;

  // State and table-ready registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tbl_ready <= 1'b0;
    end else begin
      state     <= state_next;
      tbl_ready <= tbl_ready_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next     = state;
    tbl_ready_next = tbl_ready;
    cmd            = '0;
    cmd.res        = RK_NONE;
    s_tready       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_DECODE;
        end
      end

      ST_DECODE: begin
        priority if (stat.func == FUNC_FORMAT) begin
          cmd.fmt_start = 1'b1;
          state_next    = ST_FORMAT;
        end else if (!tbl_ready) begin
          cmd.res    = RK_NOT_READY;
          state_next = ST_DONE;
        end else if (stat.func == FUNC_ALLOC) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end else if (!stat.in_range) begin
          cmd.res    = RK_RANGE;
          state_next = ST_DONE;
        end else if (stat.func == FUNC_READ) begin
          cmd.rd_issue = 1'b1;
          state_next   = ST_READ;
        end else begin
          cmd.res    = stat.value_ok ? RK_WRITE : RK_VALUE;
          state_next = ST_DONE;
        end
      end

      ST_READ: begin
        cmd.res    = RK_READ;
        state_next = ST_DONE;
      end

      // The scan reads one entry per cycle until a free one shows up or the disk size is passed.
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        priority if (stat.scan_hit) begin
          cmd.res    = RK_ALLOC;
          state_next = ST_DONE;
        end else if (stat.scan_done) begin
          cmd.res    = RK_NO_FREE;
          state_next = ST_DONE;
        end else begin
          state_next = ST_SCAN;
        end
      end

      // The format sweep steps one entry per cycle over the whole store, writing each disk or reserved entry.
      ST_FORMAT: begin
        cmd.fmt_run = 1'b1;
        if (stat.fmt_last) begin
          cmd.res        = RK_FORMAT;
          tbl_ready_next = 1'b1;
          state_next     = ST_DONE;
        end
      end

      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/fte_datapath.sv
module fte_datapath
  import fte_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Configuration channel.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data,
  // Input payload: tuser [1:0] func; tdata [9:0] entry_index, [20:10] entry_value.
  input  logic [1:0]        s_tuser,
  input  logic [23:0]       s_tdata,
  // Output beat.
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,
  output logic [4:0]        m_tuser,
  // Controller link.
  input  fte_cmd_t          cmd,
  output fte_stat_t         stat
);

  logic [SIZE_W-1:0]        disk_blocks;
  logic [SIZE_W-1:0]        n_eff;

  func_t                    in_func;
  logic [ADDR_W-1:0]        in_idx;
  logic signed [VALUE_W-1:0] in_val;

  logic signed [VALUE_W-1:0] mem [MAX_BLOCKS];
  logic signed [VALUE_W-1:0] rd_data;
  logic                     mem_we, mem_re;
  logic [ADDR_W-1:0]        mem_wa, mem_ra;
  logic signed [VALUE_W-1:0] mem_wd;

  logic [SIZE_W-1:0]        scan_addr;
  logic                     scan_dv;
  logic [ADDR_W-1:0]        scan_tag;
  logic                     scan_issue;

  logic [ADDR_W-1:0]        fmt_addr;
  logic [SIZE_W-1:0]        fmt_addr_ext;
  logic [SIZE_W-1:0]        fmt_dir;
  logic                     fmt_found;
  logic [SIZE_W-1:0]        fmt_dir_calc;
  logic [SIZE_W-1:0]        fat_blocks;
  logic                     fmt_we;
  logic signed [VALUE_W-1:0] fmt_wd;

  logic signed [VALUE_W-1:0] res_read_value;
  status_t                  res_status;
  logic                     res_found;
  logic [ADDR_W-1:0]        res_blk;
  logic                     res_wbv;
  logic [ADDR_W-1:0]        res_wbb;

  // Disk size register; a size above the store depth counts as the depth.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_blocks <= DISK_BLOCKS_RESET;
    end else if (cfg_valid) begin
      disk_blocks <= cfg_data;
    end
  end

  assign n_eff = (disk_blocks > SIZE_W'(MAX_BLOCKS)) ? SIZE_W'(MAX_BLOCKS) : disk_blocks;

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_func <= func_t'(s_tuser);
      in_idx  <= s_tdata[ADDR_W-1:0];
      in_val  <= s_tdata[ADDR_W+VALUE_W-1:ADDR_W];
    end
  end

  // Range and value checks for read and write.
  assign stat.func     = in_func;
  assign stat.in_range = {1'b0, in_idx} < n_eff;
  assign stat.value_ok = (in_val == CODE_FREE) || (in_val == CODE_INODE) ||
                         (in_val == CODE_END) ||
                         (!in_val[VALUE_W-1] && ({1'b0, in_val[ADDR_W-1:0]} < n_eff));

  // Allocation scan: address issue, then tag and flag for the registered read.
  assign scan_issue = scan_addr < n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_dv <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_dv <= 1'b0;
    end else if (cmd.scan_run) begin
      scan_dv <= scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_addr <= '0;
    end else if (cmd.scan_run && scan_issue) begin
      scan_tag  <= scan_addr[ADDR_W-1:0];
      scan_addr <= scan_addr + SIZE_W'(1);
    end
  end

  assign stat.scan_hit  = scan_dv && (rd_data == CODE_FREE);
  assign stat.scan_done = !scan_dv && !scan_issue;

  // Format sweep: the reserved run covers entry 0, any gap and the table blocks.
  assign fat_blocks   = SIZE_W'((13'(n_eff) + 13'(ENTRIES_PER_BLOCK - 1)) / ENTRIES_PER_BLOCK);
  assign fmt_dir_calc = SIZE_W'(TABLE_START) + fat_blocks;
  assign fmt_addr_ext = {1'b0, fmt_addr};

  always_ff @(posedge clk) begin
    if (cmd.fmt_start) begin
      fmt_addr  <= '0;
      fmt_dir   <= fmt_dir_calc;
      fmt_found <= fmt_dir_calc < n_eff;
    end else if (cmd.fmt_run) begin
      fmt_addr  <= fmt_addr + ADDR_W'(1);
    end
  end

  assign stat.fmt_last = fmt_addr == ADDR_W'(MAX_BLOCKS - 1);

  always_comb begin
    fmt_we = (fmt_addr_ext < fmt_dir) || (fmt_addr_ext < n_eff);
    priority if (fmt_addr_ext < fmt_dir) begin
      fmt_wd = CODE_RESERVED;
    end else if (fmt_addr_ext == fmt_dir) begin
      fmt_wd = CODE_END;
    end else begin
      fmt_wd = CODE_FREE;
    end
  end

  // Entry store ports.
  always_comb begin
    mem_we = cmd.fmt_run ? fmt_we : (cmd.res == RK_WRITE);
    mem_wa = cmd.fmt_run ? fmt_addr : in_idx;
    mem_wd = cmd.fmt_run ? fmt_wd : in_val;
    mem_re = cmd.rd_issue || (cmd.scan_run && scan_issue);
    mem_ra = cmd.scan_run ? scan_addr[ADDR_W-1:0] : in_idx;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  // Result build.
  always_ff @(posedge clk) begin
    if (cmd.res != RK_NONE) begin
      res_read_value <= '0;
      res_status     <= STATUS_OK;
      res_found      <= 1'b0;
      res_blk        <= '0;
      res_wbv        <= 1'b0;
      res_wbb        <= '0;
      unique case (cmd.res)
        RK_NOT_READY: res_status <= STATUS_NOT_READY;
        RK_RANGE:     res_status <= STATUS_RANGE;
        RK_VALUE:     res_status <= STATUS_VALUE;
        RK_NO_FREE:   res_status <= STATUS_NO_FREE;
        RK_READ:      res_read_value <= rd_data;
        RK_WRITE: begin
          res_wbv <= 1'b1;
          res_wbb <= ADDR_W'(in_idx / ENTRIES_PER_BLOCK) + ADDR_W'(TABLE_START);
        end
        RK_ALLOC: begin
          res_found <= 1'b1;
          res_blk   <= scan_tag;
        end
        RK_FORMAT: begin
          res_found  <= fmt_found;
          res_blk    <= fmt_found ? fmt_dir[ADDR_W-1:0] : '0;
          res_status <= fmt_found ? STATUS_OK : STATUS_NO_FREE;
        end
        default: res_status <= STATUS_OK;
      endcase
    end
  end

  // Output register.
  assign stat.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {1'b0, res_wbb, res_blk, res_read_value};
      m_tuser <= {res_wbv, res_found, res_status};
    end
  end

endmodule

### rtl/core/fat_table_engine_core.sv
// Allocate time is set by the one-entry-a-cycle scan over the effective disk size;
// format time is set by the sweep that steps one store entry a cycle over the whole store.
// One operation is in flight at a time; the next beat is taken once it completes.
// Reset clears the controller and output valid and sets the disk size to 1024;
// the entry store is undefined until a format, and operations before it report not ready.
module fat_table_engine_core
  import fte_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Configuration channel: disk_blocks.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data,
  // Input stream.
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,  // [9:0] entry_index, [20:10] entry_value
  input  logic [1:0]        s_tuser,  // [1:0] func
  // Output stream.
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,  // [10:0] read_value, [20:11] block_number,
                                      // [30:21] writeback_disk_block
  output logic [4:0]        m_tuser   // [2:0] status, [3] found, [4] writeback_valid
);

  fte_cmd_t  cmd;
  fte_stat_t stat;

  fte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fte_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

`ifndef ASSERT_OFF
  // A result is loaded only into a free output register.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over an unaccepted output beat");

  // Only one operation is in flight: an accepted beat closes the input side.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an operation is in flight");

  // An output beat appears only after the controller loads a result.
  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.out_load))
    else $error("output valid without a result load");
`endif

endmodule
